// File: design/skfl_pkg.sv
// Shared constants, status codes and controller/datapath types for the
// sorted key floor lookup block. No dependencies.
package skfl_pkg;

    localparam int TABLE_DEPTH = 2048;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int KEY_W    = 23;
    localparam int RATE_W   = 32;
    localparam int AMOUNT_W = 22;
    localparam int STATUS_W = 3;
    localparam int PROD_W   = 54;

    localparam logic [0:0] MODE_INSERT = 1'b0;
    localparam logic [0:0] MODE_QUERY  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_INSERTED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd2;
    localparam logic [STATUS_W-1:0] ST_CONVERTED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NO_EARLIER = 3'd4;

    typedef struct packed {
        logic load;    // capture the accepted word and clear the scan state
        logic issue;   // read the entry at the scan index and advance it
        logic finish;  // build the result word and update the table
    } skfl_cmd_t;

    typedef struct packed {
        logic scan_end;  // every stored entry has been read
        logic out_free;  // the output register can take a result word
    } skfl_stat_t;

endpackage

// File: design/skfl_item_if.sv
// Input channel of the floor lookup block: valid/ready plus one item word.
// Depends on skfl_pkg.
interface skfl_item_if
    import skfl_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [0:0]          mode;
    logic [KEY_W-1:0]    date_key;
    logic [RATE_W-1:0]   rate;
    logic [AMOUNT_W-1:0] amount;

    modport source (output valid, mode, date_key, rate, amount, input ready);
    modport sink   (input valid, mode, date_key, rate, amount, output ready);
endinterface

// File: design/skfl_result_if.sv
// Output channel of the floor lookup block: valid/ready plus one result word.
// Depends on skfl_pkg.
interface skfl_result_if
    import skfl_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [PROD_W-1:0]   product;

    modport source (output valid, status, product, input ready);
    modport sink   (input valid, status, product, output ready);
endinterface

// File: design/skfl_ctrl.sv
// Controller of the floor lookup block: sequences accept, table scan and
// result. Depends on skfl_pkg.
module skfl_ctrl
    import skfl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  skfl_stat_t stat,
    output skfl_cmd_t  cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.scan_end)
                    state_next = S_DONE;
                else
                    cmd.issue = 1'b1;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// File: design/skfl_dp.sv
// Datapath of the floor lookup block: entry memory, scan index, best-match
// tracking, multiplier and output register. Depends on skfl_pkg.
module skfl_dp
    import skfl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  skfl_cmd_t           cmd,
    output skfl_stat_t          stat,
    input  logic [0:0]          item_mode,
    input  logic [KEY_W-1:0]    item_date_key,
    input  logic [RATE_W-1:0]   item_rate,
    input  logic [AMOUNT_W-1:0] item_amount,
    output logic                result_valid,
    input  logic                result_ready,
    output logic [STATUS_W-1:0] result_status,
    output logic [PROD_W-1:0]   result_product
);

    localparam int ENTRY_W = KEY_W + RATE_W;

    // Entry memory: one write port, one registered read port.
    logic [ENTRY_W-1:0] mem_reg [TABLE_DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    logic [0:0]          mode_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [RATE_W-1:0]   rate_reg;
    logic [AMOUNT_W-1:0] amount_reg;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              rd_valid_reg;
    logic              found_reg, found_next;
    logic              dup_reg, dup_next;
    logic [KEY_W-1:0]  best_key_reg, best_key_next;
    logic [RATE_W-1:0] best_rate_reg, best_rate_next;

    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [PROD_W-1:0]   out_product_reg, out_product_next;

    logic [KEY_W-1:0]  rd_key;
    logic [RATE_W-1:0] rd_rate;
    logic [PROD_W-1:0] mult;
    logic              do_write;

    assign rd_key  = rd_data_reg[ENTRY_W-1:RATE_W];
    assign rd_rate = rd_data_reg[RATE_W-1:0];
    assign mult    = best_rate_reg * amount_reg;

    assign stat.scan_end = (idx_reg == count_reg);
    assign stat.out_free = !out_valid_reg || result_ready;

    assign do_write = cmd.finish && (mode_reg == MODE_INSERT) && !dup_reg
                      && (count_reg < CNT_W'(TABLE_DEPTH));

    // Scan and best-match update.
    always_comb
    begin
        idx_next       = idx_reg;
        found_next     = found_reg;
        dup_next       = dup_reg;
        best_key_next  = best_key_reg;
        best_rate_next = best_rate_reg;
        count_next     = count_reg;
        if (cmd.load)
        begin
            idx_next   = '0;
            found_next = 1'b0;
            dup_next   = 1'b0;
        end
        else
        begin
            if (cmd.issue)
                idx_next = idx_reg + 1'b1;
            if (rd_valid_reg)
            begin
                if (rd_key == key_reg)
                    dup_next = 1'b1;
                if ((rd_key <= key_reg) && (!found_reg || (rd_key > best_key_reg)))
                begin
                    found_next     = 1'b1;
                    best_key_next  = rd_key;
                    best_rate_next = rd_rate;
                end
            end
        end
        if (do_write)
            count_next = count_reg + 1'b1;
    end

    // Result word.
    always_comb
    begin
        out_status_next  = out_status_reg;
        out_product_next = out_product_reg;
        out_valid_next   = out_valid_reg && !result_ready;
        if (cmd.finish)
        begin
            out_valid_next   = 1'b1;
            out_product_next = '0;
            if (mode_reg == MODE_INSERT)
            begin
                if (dup_reg)
                    out_status_next = ST_DUPLICATE;
                else if (do_write)
                    out_status_next = ST_INSERTED;
                else
                    out_status_next = ST_FULL;
            end
            else if (found_reg)
            begin
                out_status_next  = ST_CONVERTED;
                out_product_next = mult;
            end
            else
            begin
                out_status_next = ST_NO_EARLIER;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_write)
            mem_reg[count_reg[IDX_W-1:0]] <= {key_reg, rate_reg};
        if (cmd.issue)
            rd_data_reg <= mem_reg[idx_reg[IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg   <= item_mode;
            key_reg    <= item_date_key;
            rate_reg   <= item_rate;
            amount_reg <= item_amount;
        end
        best_key_reg    <= best_key_next;
        best_rate_reg   <= best_rate_next;
        out_status_reg  <= out_status_next;
        out_product_reg <= out_product_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            idx_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            found_reg     <= 1'b0;
            dup_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            rd_valid_reg  <= cmd.issue;
            found_reg     <= found_next;
            dup_reg       <= dup_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result_valid   = out_valid_reg;
    assign result_status  = out_status_reg;
    assign result_product = out_product_reg;

    // The fill count never passes the table depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count above table depth");

    // A stored insert grows the table by exactly one entry.
    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        do_write |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("insert did not advance the entry count");

    // A full report only comes from a full table.
    a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish && (out_status_next == ST_FULL) |-> count_reg == CNT_W'(TABLE_DEPTH))
        else $error("table full reported below depth");

    // Only a conversion carries a nonzero product.
    a_product_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_status_reg != ST_CONVERTED) |-> out_product_reg == '0)
        else $error("nonzero product without conversion");

endmodule

// File: design/sorted_key_floor_lookup_scale.sv
// Top level of the sorted key floor lookup block: controller plus datapath.
// Depends on skfl_pkg, skfl_item_if, skfl_result_if, skfl_ctrl and skfl_dp.
//
// The block keeps a table of up to TABLE_DEPTH (date key, rate) entries.
// Each word on the item channel either inserts an entry (mode 0) or asks for
// a conversion (mode 1). An insert of a key already stored is reported as a
// duplicate and leaves the table alone; an insert into a full table is
// reported as full. A conversion finds the stored entry with the greatest
// key not above the query key and returns rate times amount with 24
// fraction bits, or reports that no earlier entry exists.
//
// Every item word produces exactly one word on the result channel.
// After an item is accepted, the single read port of the entry memory is
// walked once over the stored entries, one entry per cycle, then the
// result is formed and registered. One item is worked on at a time, so the
// item channel is ready again in the cycle after the result is formed.
//
// Reset clears the entry count, so the table starts empty; there is no
// clearing pass. The result sits in an output register; if the receiver
// stalls, the block can still accept and scan the next item, and holds the
// new result until the register is free.
module sorted_key_floor_lookup_scale
    import skfl_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    skfl_item_if.sink     item,
    skfl_result_if.source result
);

    skfl_cmd_t  cmd;
    skfl_stat_t stat;

    skfl_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item.ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    skfl_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .item_mode      (item.mode),
        .item_date_key  (item.date_key),
        .item_rate      (item.rate),
        .item_amount    (item.amount),
        .result_valid   (result.valid),
        .result_ready   (result.ready),
        .result_status  (result.status),
        .result_product (result.product)
    );

endmodule

// File: bench/skfl_floor_checker.sv
`timescale 1ns / 100ps
// Checker for the sorted key floor lookup block: watches both channels,
// keeps its own copy of the rate table and compares every result word.
// Depends on skfl_pkg, skfl_item_if and skfl_result_if.
module skfl_floor_checker
    import skfl_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    skfl_item_if   item,
    skfl_result_if result,
    output int     mismatches,
    output int     outstanding
);

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [PROD_W-1:0]   product;
    } reply_t;

    logic [KEY_W-1:0]  rate_table_keys  [TABLE_DEPTH];
    logic [RATE_W-1:0] rate_table_rates [TABLE_DEPTH];
    int unsigned       rate_table_count;
    reply_t            awaited_replies [$];

    // Inserts update the table copy; queries pick the greatest key not above
    // the query key and scale its rate by the amount.
    function automatic reply_t insert_or_convert(logic [0:0] mode, logic [KEY_W-1:0] key,
                                                 logic [RATE_W-1:0] rate,
                                                 logic [AMOUNT_W-1:0] amount);
        reply_t            reply;
        bit                found;
        logic [KEY_W-1:0]  best_key;
        logic [RATE_W-1:0] best_rate;
        logic [PROD_W-1:0] wide_rate;
        logic [PROD_W-1:0] wide_amount;

        reply.product = '0;
        found         = 1'b0;
        best_key      = '0;
        best_rate     = '0;
        if (mode == MODE_INSERT)
        begin
            for (int i = 0; i < rate_table_count; i++)
            begin
                if (rate_table_keys[i] == key)
                begin
                    reply.status = ST_DUPLICATE;
                    return reply;
                end
            end
            if (rate_table_count >= TABLE_DEPTH)
            begin
                reply.status = ST_FULL;
                return reply;
            end
            rate_table_keys[rate_table_count]  = key;
            rate_table_rates[rate_table_count] = rate;
            rate_table_count++;
            reply.status = ST_INSERTED;
            return reply;
        end
        for (int i = 0; i < rate_table_count; i++)
        begin
            if (rate_table_keys[i] <= key && (!found || rate_table_keys[i] > best_key))
            begin
                found     = 1'b1;
                best_key  = rate_table_keys[i];
                best_rate = rate_table_rates[i];
            end
        end
        if (!found)
        begin
            reply.status = ST_NO_EARLIER;
            return reply;
        end
        wide_rate     = PROD_W'(best_rate);
        wide_amount   = PROD_W'(amount);
        reply.status  = ST_CONVERTED;
        reply.product = wide_rate * wide_amount;
        return reply;
    endfunction

    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("%0t ns: %s", $time, what);
        end
    endtask

    // A result word always belongs to an earlier item, so it is checked
    // before the item accepted at the same edge is predicted.
    always @(posedge clk or negedge rst_n)
    begin
        reply_t want;

        if (!rst_n)
        begin
            rate_table_count = 0;
            awaited_replies.delete();
            outstanding = 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (awaited_replies.size() == 0)
                begin
                    note_mismatch($sformatf("unexpected result word: status %0d product %h",
                                            result.status, result.product));
                end
                else
                begin
                    want = awaited_replies.pop_front();
                    if (want.status !== result.status || want.product !== result.product)
                    begin
                        note_mismatch($sformatf(
                            "status exp %0d got %0d, product exp %h got %h",
                            want.status, result.status, want.product, result.product));
                    end
                end
            end
            if (item.valid && item.ready)
            begin
                awaited_replies.push_back(insert_or_convert(item.mode, item.date_key,
                                                            item.rate, item.amount));
            end
            outstanding = awaited_replies.size();
        end
    end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// Top of the floor lookup testbench: clock, reset, stimulus and verdict.
// Depends on skfl_pkg, both channel interfaces, the block and skfl_floor_checker.
module tb_top;
    import skfl_pkg::*;

    logic clk;
    logic rst_n;

    // While quiet is set neither side idles; otherwise each side may idle,
    // with a chance of 12 in 100 each time it decides.
    bit   quiet;
    int   mismatches;
    int   outstanding;

    // Keys that were actually stored, kept only to steer the stimulus toward
    // exact hits, near misses and duplicates.
    logic [KEY_W-1:0] stored_keys [$];
    bit               key_taken [logic [KEY_W-1:0]];

    skfl_item_if   item_ch ();
    skfl_result_if result_ch ();

    sorted_key_floor_lookup_scale u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    skfl_floor_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item_ch),
        .result      (result_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Hard stop. The slowest correct run, with every item scanning a full
    // table and both sides stalling, stays well below this bound.
    initial
    begin
        #300000000;
        $display("tb_top NOT OK");
        $finish;
    end

    // The receiver changes ready only at the falling edge, so the block and
    // the checker see a stable value at the rising edge.
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            result_ch.ready = quiet || ($urandom_range(99) >= 12);
        end
    end

    function automatic logic [KEY_W-1:0] date_key_of(input int year, input int month,
                                                     input int day);
        return KEY_W'((year << 9) | (month << 5) | day);
    endfunction

    // Mix of plausible dates, stored keys, keys just around stored ones,
    // keys at both ends of the range and fully random keys.
    function automatic logic [KEY_W-1:0] pick_key();
        int               sel;
        logic [KEY_W-1:0] base;

        sel = $urandom_range(99);
        if (sel < 40)
        begin
            return date_key_of($urandom_range(2024, 2009), $urandom_range(12, 1),
                               $urandom_range(31, 1));
        end
        if (sel < 75 && stored_keys.size() != 0)
        begin
            base = stored_keys[$urandom_range(stored_keys.size() - 1)];
            if (sel < 60)
            begin
                return base;
            end
            return base + KEY_W'($urandom_range(80)) - KEY_W'(40);
        end
        if (sel < 85)
        begin
            return ($urandom_range(1) != 0) ? KEY_W'($urandom_range(63))
                                            : ~KEY_W'($urandom_range(63));
        end
        return KEY_W'($urandom);
    endfunction

    function automatic logic [RATE_W-1:0] pick_rate();
        int sel;

        sel = $urandom_range(19);
        if (sel == 0)
        begin
            return '0;
        end
        if (sel == 1)
        begin
            return '1;
        end
        return RATE_W'($urandom);
    endfunction

    function automatic logic [AMOUNT_W-1:0] pick_amount();
        int sel;

        sel = $urandom_range(19);
        if (sel == 0)
        begin
            return '0;
        end
        if (sel == 1)
        begin
            return '1;
        end
        return AMOUNT_W'($urandom);
    endfunction

    // Offers one word at a falling edge, possibly after some idle cycles with
    // garbage on the payload, and holds it until the block takes it. Valid
    // stays high after the handshake until the next call or drain decides.
    task automatic send_word(input logic [0:0] mode, input logic [KEY_W-1:0] key,
                             input logic [RATE_W-1:0] rate,
                             input logic [AMOUNT_W-1:0] amount);
        @(negedge clk);
        while (!quiet && $urandom_range(99) < 12)
        begin
            item_ch.valid    = 1'b0;
            item_ch.date_key = KEY_W'($urandom);
            item_ch.rate     = RATE_W'($urandom);
            item_ch.amount   = AMOUNT_W'($urandom);
            @(negedge clk);
        end
        item_ch.valid    = 1'b1;
        item_ch.mode     = mode;
        item_ch.date_key = key;
        item_ch.rate     = rate;
        item_ch.amount   = amount;
        do
        begin
            @(posedge clk);
        end
        while (!item_ch.ready);
        if (mode == MODE_INSERT && !key_taken.exists(key) && stored_keys.size() < TABLE_DEPTH)
        begin
            key_taken[key] = 1'b1;
            stored_keys.push_back(key);
        end
    endtask

    // Drops valid and waits until every result word owed has arrived.
    task automatic drain();
        @(negedge clk);
        item_ch.valid = 1'b0;
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
    endtask

    initial
    begin
        int n;

        item_ch.valid    = 1'b0;
        item_ch.mode     = MODE_INSERT;
        item_ch.date_key = '0;
        item_ch.rate     = '0;
        item_ch.amount   = '0;
        quiet            = 1'b1;
        rst_n            = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        quiet = 1'b0;

        // Directed part. Queries on the empty table come first, then a single
        // entry is probed for an exact match, an earlier key and a key later
        // than everything stored. Rate on a query and amount on an insert
        // carry junk on purpose, since the block must ignore them.
        send_word(MODE_QUERY, '0, '1, '1);
        send_word(MODE_QUERY, '1, '0, '1);
        send_word(MODE_INSERT, 23'd1000, '1, '1);
        send_word(MODE_INSERT, 23'd1000, 32'h1234_5678, '0);
        send_word(MODE_QUERY, 23'd1000, '0, '1);
        send_word(MODE_QUERY, 23'd999, '1, '1);
        send_word(MODE_QUERY, '1, '0, 22'h00_1000);
        // Both ends of the key range, with a zero rate and the smallest nonzero rate.
        send_word(MODE_INSERT, '0, '0, '1);
        send_word(MODE_INSERT, '1, 32'h0000_0001, '0);
        send_word(MODE_QUERY, '0, '1, '1);
        send_word(MODE_QUERY, '1, '0, '1);
        send_word(MODE_QUERY, 23'd500, '0, '0);
        // Real dates: a rate of one and one and a half, looked up between,
        // on and just below the stored days.
        send_word(MODE_INSERT, date_key_of(2011, 1, 3), 32'h0000_1000, '0);
        send_word(MODE_INSERT, date_key_of(2011, 1, 20), 32'h0000_1800, '0);
        send_word(MODE_QUERY, date_key_of(2011, 1, 5), '0, 22'h00_1800);
        send_word(MODE_QUERY, date_key_of(2011, 1, 20), '0, 22'h00_0800);
        send_word(MODE_QUERY, date_key_of(2011, 1, 19), '0, 22'h00_0001);
        send_word(MODE_INSERT, 23'd1000, '0, '0);
        send_word(MODE_QUERY, 23'd1001, '1, 22'h2A_AAAA);
        // Alternating bit patterns on every field.
        send_word(MODE_INSERT, 23'h55_5555, 32'hAAAA_AAAA, 22'h15_5555);
        send_word(MODE_QUERY, 23'h2A_AAAA, 32'h5555_5555, 22'h15_5555);

        // Random part on a slowly growing table. One stretch runs with no
        // idling on either side, and once the sender waits for the block to
        // empty completely before going on.
        for (n = 0; n < 265; n++)
        begin
            quiet = (n >= 100 && n < 170);
            if (n == 200)
            begin
                drain();
            end
            if ($urandom_range(99) < 35)
            begin
                send_word(MODE_INSERT, pick_key(), pick_rate(), AMOUNT_W'($urandom));
            end
            else
            begin
                send_word(MODE_QUERY, pick_key(), RATE_W'($urandom), pick_amount());
            end
        end
        quiet = 1'b0;

        send_word(MODE_QUERY, '0, '1, '1);
        send_word(MODE_QUERY, '1, '1, '1);

        // Wait for the last result word, then leave room for a stray one.
        drain();
        repeat (2100) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("tb_top OK");
        end
        else
        begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
